// ----- rtl/core/pitb_pkg.sv -----
// ----------------------------------------------------------------------------
// pitb_pkg
// Shared widths and types for the point-in-tetrahedron barycentric test.
// ----------------------------------------------------------------------------
package pitb_pkg;

    localparam int COORD_WIDTH      = 16;
    localparam int WEIGHT_FRAC_BITS = 16;
    localparam int WEIGHT_WIDTH     = WEIGHT_FRAC_BITS + 2;

    // Exact determinant widths
    localparam int DIFF_W  = COORD_WIDTH + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int MINOR_W = PROD_W + 1;
    localparam int BIG_W   = DIFF_W + MINOR_W;
    localparam int VOL_W   = BIG_W + 2;
    localparam int MAG_W   = VOL_W;

    // Quotient carries one extra bit that flags overflow
    localparam int QUOT_W = WEIGHT_WIDTH + 1;
    localparam int REM_W  = MAG_W + QUOT_W;

    localparam int VOL_STAGES = 5;
    localparam int DIV_STAGES = QUOT_W;

    typedef logic signed [COORD_WIDTH-1:0] coord_t;

    typedef struct packed {
        coord_t z;
        coord_t y;
        coord_t x;
    } vec_t;

    typedef struct packed {
        logic       enclosed;
        logic       degen;
        logic [3:0] neg;
    } flags_t;

endpackage

// ----- rtl/core/pitb_volume.sv -----
// ----------------------------------------------------------------------------
// pitb_volume
// Five-stage pipeline for the homogeneous 4x4 determinant of four vertices.
// ----------------------------------------------------------------------------
module pitb_volume
    import pitb_pkg::*;
(
    input  logic                    clk,
    input  vec_t                    a,
    input  vec_t                    b,
    input  vec_t                    c,
    input  vec_t                    d,
    output logic signed [VOL_W-1:0] vol
);

    logic signed [DIFF_W-1:0]  ux_reg, uy_reg, uz_reg;
    logic signed [DIFF_W-1:0]  vx_reg, vy_reg, vz_reg;
    logic signed [DIFF_W-1:0]  wx_reg, wy_reg, wz_reg;
    logic signed [DIFF_W-1:0]  ux2_reg, uy2_reg, uz2_reg;
    logic signed [PROD_W-1:0]  pa_reg, pb_reg, pc_reg, pd_reg, pe_reg, pf_reg;
    logic signed [DIFF_W-1:0]  ux3_reg, uy3_reg, uz3_reg;
    logic signed [MINOR_W-1:0] m1_reg, m2_reg, m3_reg;
    logic signed [BIG_W-1:0]   q1_reg, q2_reg, q3_reg;
    logic signed [VOL_W-1:0]   vol_reg;

    always_ff @(posedge clk)
    begin
        // edge vectors from vertex a
        ux_reg <= DIFF_W'($signed(b.x)) - DIFF_W'($signed(a.x));
        uy_reg <= DIFF_W'($signed(b.y)) - DIFF_W'($signed(a.y));
        uz_reg <= DIFF_W'($signed(b.z)) - DIFF_W'($signed(a.z));
        vx_reg <= DIFF_W'($signed(c.x)) - DIFF_W'($signed(a.x));
        vy_reg <= DIFF_W'($signed(c.y)) - DIFF_W'($signed(a.y));
        vz_reg <= DIFF_W'($signed(c.z)) - DIFF_W'($signed(a.z));
        wx_reg <= DIFF_W'($signed(d.x)) - DIFF_W'($signed(a.x));
        wy_reg <= DIFF_W'($signed(d.y)) - DIFF_W'($signed(a.y));
        wz_reg <= DIFF_W'($signed(d.z)) - DIFF_W'($signed(a.z));

        // minor products
        pa_reg  <= PROD_W'(vy_reg) * PROD_W'(wz_reg);
        pb_reg  <= PROD_W'(vz_reg) * PROD_W'(wy_reg);
        pc_reg  <= PROD_W'(vx_reg) * PROD_W'(wz_reg);
        pd_reg  <= PROD_W'(vz_reg) * PROD_W'(wx_reg);
        pe_reg  <= PROD_W'(vx_reg) * PROD_W'(wy_reg);
        pf_reg  <= PROD_W'(vy_reg) * PROD_W'(wx_reg);
        ux2_reg <= ux_reg;
        uy2_reg <= uy_reg;
        uz2_reg <= uz_reg;

        // minors
        m1_reg  <= MINOR_W'(pa_reg) - MINOR_W'(pb_reg);
        m2_reg  <= MINOR_W'(pc_reg) - MINOR_W'(pd_reg);
        m3_reg  <= MINOR_W'(pe_reg) - MINOR_W'(pf_reg);
        ux3_reg <= ux2_reg;
        uy3_reg <= uy2_reg;
        uz3_reg <= uz2_reg;

        // cofactor products
        q1_reg <= BIG_W'(ux3_reg) * BIG_W'(m1_reg);
        q2_reg <= BIG_W'(uy3_reg) * BIG_W'(m2_reg);
        q3_reg <= BIG_W'(uz3_reg) * BIG_W'(m3_reg);

        // negated 3x3 determinant
        vol_reg <= VOL_W'(q2_reg) - VOL_W'(q1_reg) - VOL_W'(q3_reg);
    end

    assign vol = vol_reg;

endmodule

// ----- rtl/core/pitb_divider.sv -----
// ----------------------------------------------------------------------------
// pitb_divider
// Pipelined restoring divider, one quotient bit per stage, MSB first.
// ----------------------------------------------------------------------------
module pitb_divider
    import pitb_pkg::*;
(
    input  logic              clk,
    input  logic [MAG_W-1:0]  num,
    input  logic [MAG_W-1:0]  den,
    output logic [QUOT_W-1:0] quot
);

    logic [REM_W-1:0]  rem_reg  [QUOT_W-1];
    logic [MAG_W-1:0]  den_reg  [QUOT_W-1];
    logic [QUOT_W-1:0] quot_reg [QUOT_W];

    for (genvar s = 0; s < QUOT_W; s++)
    begin : g_stage
        localparam int SHIFT = QUOT_W - 1 - s;

        logic [REM_W-1:0]  rem_in;
        logic [MAG_W-1:0]  den_in;
        logic [QUOT_W-1:0] quot_in;
        logic [REM_W-1:0]  trial;
        logic              ge;

        if (s == 0)
        begin : g_first
            assign rem_in  = REM_W'(num) << WEIGHT_FRAC_BITS;
            assign den_in  = den;
            assign quot_in = '0;
        end
        else
        begin : g_next
            assign rem_in  = rem_reg[s-1];
            assign den_in  = den_reg[s-1];
            assign quot_in = quot_reg[s-1];
        end

        assign trial = REM_W'(den_in) << SHIFT;
        assign ge    = rem_in >= trial;

        always_ff @(posedge clk)
        begin
            quot_reg[s] <= {quot_in[QUOT_W-2:0], ge};
        end

        if (s < QUOT_W - 1)
        begin : g_carry
            always_ff @(posedge clk)
            begin
                rem_reg[s] <= ge ? rem_in - trial : rem_in;
                den_reg[s] <= den_in;
            end
        end
    end

    assign quot = quot_reg[QUOT_W-1];

endmodule

// ----- rtl/core/point_in_tetrahedron_barycentric.sv -----
// ----------------------------------------------------------------------------
// point_in_tetrahedron_barycentric
// Barycentric point-in-tetrahedron test with saturated Q1.16 weights.
// ----------------------------------------------------------------------------
// One test enters per cycle; busy is held low, so every start is a transfer.
// The result appears on done after the transfer has passed five stages of
// determinant arithmetic, one stage of sign and magnitude, a nineteen-stage
// restoring divider (one quotient bit per stage) and an output register.
// Results cannot be held off, so done pulses for one cycle per test.
// ----------------------------------------------------------------------------
module point_in_tetrahedron_barycentric
    import pitb_pkg::*;
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic [3*COORD_WIDTH-1:0]       vertex_a,
    input  logic [3*COORD_WIDTH-1:0]       vertex_b,
    input  logic [3*COORD_WIDTH-1:0]       vertex_c,
    input  logic [3*COORD_WIDTH-1:0]       vertex_d,
    input  logic signed [COORD_WIDTH-1:0]  point_x,
    input  logic signed [COORD_WIDTH-1:0]  point_y,
    input  logic signed [COORD_WIDTH-1:0]  point_z,
    output logic                           done,
    output logic                           inside_res,
    output logic                           degenerate,
    output logic signed [WEIGHT_WIDTH-1:0] weight_a,
    output logic signed [WEIGHT_WIDTH-1:0] weight_b,
    output logic signed [WEIGHT_WIDTH-1:0] weight_c,
    output logic signed [WEIGHT_WIDTH-1:0] weight_d
);

    localparam int LATENCY = VOL_STAGES + DIV_STAGES + 2;
    localparam logic [WEIGHT_WIDTH-1:0] W_LIMIT = WEIGHT_WIDTH'(1) << (WEIGHT_WIDTH - 1);

    // The pipeline never stalls, so every start is taken.
    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    vec_t va, vb, vc, vd, vp;
    assign va = vec_t'(vertex_a);
    assign vb = vec_t'(vertex_b);
    assign vc = vec_t'(vertex_c);
    assign vd = vec_t'(vertex_d);
    assign vp = '{z: point_z, y: point_y, x: point_x};

    // ------------------------------------------------------------------
    // Determinants: the volume and the four with the point swapped in
    // ------------------------------------------------------------------
    logic signed [VOL_W-1:0] vol [5];

    pitb_volume u_vol0 (.clk(clk), .a(va), .b(vb), .c(vc), .d(vd), .vol(vol[0]));
    pitb_volume u_vol1 (.clk(clk), .a(vp), .b(vb), .c(vc), .d(vd), .vol(vol[1]));
    pitb_volume u_vol2 (.clk(clk), .a(va), .b(vp), .c(vc), .d(vd), .vol(vol[2]));
    pitb_volume u_vol3 (.clk(clk), .a(va), .b(vb), .c(vp), .d(vd), .vol(vol[3]));
    pitb_volume u_vol4 (.clk(clk), .a(va), .b(vb), .c(vc), .d(vp), .vol(vol[4]));

    // Valid bits alongside the determinant stages
    logic [VOL_STAGES-1:0] vv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vv_reg <= '0;
        end
        else
        begin
            vv_reg <= {vv_reg[VOL_STAGES-2:0], accept};
        end
    end

    // ------------------------------------------------------------------
    // Signs and magnitudes
    // ------------------------------------------------------------------
    flags_t            flags_next;
    logic [MAG_W-1:0]  mag_next [5];

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            mag_next[i] = vol[i][VOL_W-1] ? MAG_W'(-vol[i]) : MAG_W'(vol[i]);
        end
        flags_next.degen    = (vol[0] == '0);
        flags_next.enclosed = !flags_next.degen;
        for (int i = 0; i < 4; i++)
        begin
            flags_next.neg[i] = vol[i+1][VOL_W-1] != vol[0][VOL_W-1];
            // a zero determinant lies on a face and still counts as inside
            if (vol[i+1] != '0 && flags_next.neg[i])
            begin
                flags_next.enclosed = 1'b0;
            end
        end
    end

    logic             sg_vld_reg;
    flags_t           sg_flags_reg;
    logic [MAG_W-1:0] sg_mag_reg [5];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sg_vld_reg <= 1'b0;
        end
        else
        begin
            sg_vld_reg <= vv_reg[VOL_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        sg_flags_reg <= flags_next;
        for (int i = 0; i < 5; i++)
        begin
            sg_mag_reg[i] <= mag_next[i];
        end
    end

    // ------------------------------------------------------------------
    // Four dividers, with flags and valid bits riding alongside
    // ------------------------------------------------------------------
    logic [QUOT_W-1:0] quot [4];

    for (genvar i = 0; i < 4; i++)
    begin : g_div
        pitb_divider u_div (
            .clk  (clk),
            .num  (sg_mag_reg[i+1]),
            .den  (sg_mag_reg[0]),
            .quot (quot[i])
        );
    end

    logic [DIV_STAGES-1:0] dv_vld_reg;
    flags_t                dv_flags_reg [DIV_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dv_vld_reg <= '0;
        end
        else
        begin
            dv_vld_reg <= {dv_vld_reg[DIV_STAGES-2:0], sg_vld_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        dv_flags_reg[0] <= sg_flags_reg;
        for (int s = 1; s < DIV_STAGES; s++)
        begin
            dv_flags_reg[s] <= dv_flags_reg[s-1];
        end
    end

    // ------------------------------------------------------------------
    // Saturate to Q1.16 and drive the result
    // ------------------------------------------------------------------
    function automatic logic [WEIGHT_WIDTH-1:0] saturate(
        input logic [QUOT_W-1:0] q,
        input logic              neg
    );
        logic                    ovf;
        logic [WEIGHT_WIDTH-1:0] mag;
        logic [WEIGHT_WIDTH-1:0] res;
        ovf = q[QUOT_W-1];
        mag = q[WEIGHT_WIDTH-1:0];
        if (q == '0)
        begin
            res = '0;
        end
        else if (neg)
        begin
            res = (ovf || mag > W_LIMIT) ? W_LIMIT : -mag;
        end
        else
        begin
            res = (ovf || mag > W_LIMIT - 1'b1) ? W_LIMIT - 1'b1 : mag;
        end
        return res;
    endfunction

    flags_t                  fin;
    logic [WEIGHT_WIDTH-1:0] w_next [4];

    assign fin = dv_flags_reg[DIV_STAGES-1];

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            // drop the weights of a flat tetrahedron
            w_next[i] = fin.degen ? '0 : saturate(quot[i], fin.neg[i]);
        end
    end

    logic                    done_reg;
    logic                    inside_reg;
    logic                    degen_reg;
    logic [WEIGHT_WIDTH-1:0] w_reg [4];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= dv_vld_reg[DIV_STAGES-1];
        end
    end

    always_ff @(posedge clk)
    begin
        inside_reg <= fin.enclosed;
        degen_reg  <= fin.degen;
        for (int i = 0; i < 4; i++)
        begin
            w_reg[i] <= w_next[i];
        end
    end

    assign done       = done_reg;
    assign inside_res = inside_reg;
    assign degenerate = degen_reg;
    assign weight_a   = $signed(w_reg[0]);
    assign weight_b   = $signed(w_reg[1]);
    assign weight_c   = $signed(w_reg[2]);
    assign weight_d   = $signed(w_reg[3]);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        accept |-> ##LATENCY done)
        else $error("transfer did not produce a result on time");

    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(accept, LATENCY))
        else $error("result without a matching transfer");

    a_degen: assert property (@(posedge clk) disable iff (!rst_n)
        done && degenerate |-> !inside_res && weight_a == 0 && weight_b == 0
                               && weight_c == 0 && weight_d == 0)
        else $error("degenerate result carries weights or inside");

    a_inside_pos: assert property (@(posedge clk) disable iff (!rst_n)
        done && inside_res |-> !weight_a[WEIGHT_WIDTH-1] && !weight_b[WEIGHT_WIDTH-1]
                               && !weight_c[WEIGHT_WIDTH-1] && !weight_d[WEIGHT_WIDTH-1])
        else $error("inside result with a negative weight");

endmodule
